>>> design/cprt_pkg.sv
// ----------------------------------------------------------------------------
// cprt_pkg
// Types and constants shared by the clock page replacement table.
// ----------------------------------------------------------------------------
package cprt_pkg;

    localparam int DEFAULT_ENTRIES = 64;

    localparam int VA_W     = 38;
    localparam int PA_W     = 56;
    localparam int PID_W    = 31;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = VA_W;

    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 136;

    localparam logic [VA_W-1:0] TRAMPOLINE_RESET = 38'h3F_FFFF_F000;
    localparam logic [VA_W-1:0] TRAPFRAME_RESET  = 38'h3F_FFFF_E000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRAMPOLINE = 1'b0,
        REG_TRAPFRAME  = 1'b1
    } reg_index_t;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TOUCH  = 2'd2,
        OP_COUNT  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_IGNORED  = 2'd1,
        ST_NO_MATCH = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_SCAN  = 2'd2,
        S_RESP  = 2'd3
    } state_t;

    typedef struct packed {
        logic             valid;
        logic             used;
        logic [PID_W-1:0] proc;
        logic [PA_W-1:0]  phys;
        logic [VA_W-1:0]  virt;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> design/cprt_ram.sv
// ----------------------------------------------------------------------------
// cprt_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cprt_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/clock_page_replacement_table.sv
// ----------------------------------------------------------------------------
// clock_page_replacement_table
// Resident page table with second-chance clock replacement. All entries live
// in one RAM; every request that is not ignored scans it one entry per cycle.
//
//   channel   dir   signals                         contents
//   s_axis    in    tvalid tready tdata[127:0]      page request
//   m_axis    out   tvalid tready tdata[135:0]      request result
//   cfg       in    cfg_wr_en cfg_index cfg_data    excluded page addresses
//
// Scan: ignored requests skip the scan and go straight to the output
//   register. Count reads every entry. Remove, touch and add into a non-full
//   table stop at the first hit. Add into a full table walks the clock hand.
//   One RAM read per cycle sets the pace.
// Reset: a clearing pass writes every entry invalid;
//   s_axis_tready stays low during it.
// Stalls: a finished result waits in the output register while the next
//   request is taken.
// ----------------------------------------------------------------------------
module clock_page_replacement_table
    import cprt_pkg::*;
#(
    parameter int ENTRIES = DEFAULT_ENTRIES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // operation[1:0], virt_addr[39:2], phys_addr[95:40], proc_id[126:96]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status[1:0], evicted[2], victim_virt[40:3], victim_phys[96:41],
    // victim_proc[127:97], page_count[134:128]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    state_t state_reg, state_next;

    logic [VA_W-1:0] tramp_reg;
    logic [VA_W-1:0] trapf_reg;

    op_t              op_reg, op_next;
    logic [VA_W-1:0]  va_reg, va_next;
    logic [PA_W-1:0]  pa_reg, pa_next;
    logic [PID_W-1:0] pid_reg, pid_next;
    logic             sweep_reg, sweep_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] hand_reg, hand_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    status_t          status_reg, status_next;
    logic             evicted_reg, evicted_next;
    entry_t           victim_reg, victim_next;
    logic [IDX_W-1:0] clr_idx_reg, clr_idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t           rd;

    op_t              in_op;
    logic [VA_W-1:0]  in_va;
    logic [PA_W-1:0]  in_pa;
    logic [PID_W-1:0] in_pid;
    logic             accept;
    logic             excluded;
    logic             ignore;
    logic             last;
    logic             match;
    logic             scan_done;
    logic [IDX_W-1:0] idx_succ;
    logic [IDX_W-1:0] start_idx;
    logic             start_sweep;
    entry_t           new_entry;
    logic [COUNT_W-1:0] count_sat;

    cprt_ram
    #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    )
    u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd = entry_t'(ram_rdata);

    assign in_op  = op_t'(s_axis_tdata[1:0]);
    assign in_va  = s_axis_tdata[39:2];
    assign in_pa  = s_axis_tdata[95:40];
    assign in_pid = s_axis_tdata[126:96];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign excluded = (in_va == tramp_reg) || (in_va == trapf_reg);

    always_comb
    begin
        unique case (in_op)
            OP_ADD:    ignore = (in_pid == '0) || excluded;
            OP_REMOVE: ignore = excluded;
            OP_TOUCH:  ignore = (in_pid == '0);
            OP_COUNT:  ignore = 1'b0;
        endcase
    end

    assign start_sweep = (in_op == OP_ADD) && (occ_reg == FULL_CNT);
    assign start_idx   = start_sweep ? hand_reg : '0;

    assign last     = (idx_reg == LAST_IDX);
    assign idx_succ = last ? '0 : idx_reg + 1'b1;
    assign match    = rd.valid && (rd.virt == va_reg) && (rd.proc == pid_reg);

    assign new_entry = '{valid: 1'b1, used: 1'b1, proc: pid_reg,
                         phys: pa_reg, virt: va_reg};

    assign count_sat = (32'(cnt_reg) > 32'(COUNT_MAX)) ? COUNT_MAX
                                                       : COUNT_W'(cnt_reg);

    always_comb
    begin
        unique case (op_reg)
            OP_ADD:    scan_done = sweep_reg ? (rd.valid && !rd.used) : !rd.valid;
            OP_REMOVE: scan_done = match || last;
            OP_TOUCH:  scan_done = match || last;
            OP_COUNT:  scan_done = last;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = ignore ? S_RESP : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        op_next        = op_reg;
        va_next        = va_reg;
        pa_next        = pa_reg;
        pid_next       = pid_reg;
        sweep_next     = sweep_reg;
        idx_next       = idx_reg;
        hand_next      = hand_reg;
        occ_next       = occ_reg;
        cnt_next       = cnt_reg;
        status_next    = status_reg;
        evicted_next   = evicted_reg;
        victim_next    = victim_reg;
        clr_idx_next   = clr_idx_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = rd;
        ram_raddr      = idx_succ;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_idx_reg;
                ram_wdata    = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
            end
            S_IDLE:
            begin
                ram_raddr = start_idx;
                if (accept)
                begin
                    op_next      = in_op;
                    va_next      = in_va;
                    pa_next      = in_pa;
                    pid_next     = in_pid;
                    sweep_next   = start_sweep;
                    idx_next     = start_idx;
                    cnt_next     = '0;
                    evicted_next = 1'b0;
                    victim_next  = '0;
                    status_next  = ignore ? ST_IGNORED : ST_DONE;
                end
            end
            S_SCAN:
            begin
                idx_next = idx_succ;
                unique case (op_reg)
                    OP_ADD:
                    begin
                        if (sweep_reg)
                        begin
                            if (rd.valid && !rd.used)
                            begin
                                ram_we       = 1'b1;
                                ram_wdata    = new_entry;
                                evicted_next = 1'b1;
                                victim_next  = rd;
                                hand_next    = idx_reg;
                            end
                            else
                            begin
                                ram_we         = rd.valid;
                                ram_wdata.used = 1'b0;
                                hand_next      = idx_succ;
                            end
                        end
                        else if (!rd.valid)
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = new_entry;
                            occ_next  = occ_reg + 1'b1;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (match)
                        begin
                            ram_we          = 1'b1;
                            ram_wdata.valid = 1'b0;
                            ram_wdata.used  = 1'b0;
                            if (occ_reg != '0)
                            begin
                                occ_next = occ_reg - 1'b1;
                            end
                        end
                        else if (last)
                        begin
                            status_next = ST_NO_MATCH;
                        end
                    end
                    OP_TOUCH:
                    begin
                        if (match)
                        begin
                            ram_we         = 1'b1;
                            ram_wdata.used = 1'b1;
                        end
                        else if (last)
                        begin
                            status_next = ST_NO_MATCH;
                        end
                    end
                    OP_COUNT:
                    begin
                        if (rd.valid && (rd.proc == pid_reg))
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                endcase
            end
            S_RESP:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, count_sat, victim_reg.proc,
                                      victim_reg.phys, victim_reg.virt,
                                      evicted_reg, status_reg};
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            hand_reg      <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
            tramp_reg     <= TRAMPOLINE_RESET;
            trapf_reg     <= TRAPFRAME_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            hand_reg      <= hand_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                unique case (reg_index_t'(cfg_index))
                    REG_TRAMPOLINE: tramp_reg <= cfg_data;
                    REG_TRAPFRAME:  trapf_reg <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        va_reg       <= va_next;
        pa_reg       <= pa_next;
        pid_reg      <= pid_next;
        sweep_reg    <= sweep_next;
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        status_reg   <= status_next;
        evicted_reg  <= evicted_next;
        victim_reg   <= victim_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= FULL_CNT)
        else $error("occupancy above table size");

    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_SCAN) || (state_reg == S_RESP))
        else $error("accepted request not processed");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && ram_we |-> ram_waddr != ram_raddr)
        else $error("scan reads the entry being written");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && (op_reg == OP_ADD) && sweep_reg && scan_done
        |-> occ_reg == FULL_CNT)
        else $error("eviction from a table that is not full");

    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP) && out_valid_reg && !m_axis_tready
        |=> state_reg == S_RESP)
        else $error("result dropped while output stalled");
`endif

endmodule

>>> tb/sv/clock_page_replacement_table_tb.sv
// ----------------------------------------------------------------------------
// clock_page_replacement_table_tb
// Drives page requests into the table and checks every reply against an
// in-bench model of the resident page table with second-chance clock
// replacement, or a directed row's fixed reply. Directed requests come
// first, then random phases under different excluded-page settings, with
// random idling on both streams, a long reply stall and a full drain pause.
// ----------------------------------------------------------------------------
module clock_page_replacement_table_tb;
    import cprt_pkg::*;

    localparam int ENTRIES    = DEFAULT_ENTRIES;
    localparam int SEGMENTS   = 5;
    localparam int SEG_ITEMS  = 260;
    localparam int BLOCK_LEN  = 100;
    localparam int HOLD_LEN   = 400;
    localparam int SETTLE     = ENTRIES + 8;
    localparam int STALL_CAP  = 4000;

    localparam logic [VA_W-1:0]  VA_ONES  = '1;
    localparam logic [PA_W-1:0]  PA_ONES  = '1;
    localparam logic [PID_W-1:0] PID_ONES = '1;

    typedef struct packed {
        op_t              op;
        logic [VA_W-1:0]  va;
        logic [PA_W-1:0]  pa;
        logic [PID_W-1:0] pid;
    } page_req_t;

    typedef struct packed {
        status_t            status;
        logic               evicted;
        logic [VA_W-1:0]    victim_virt;
        logic [PA_W-1:0]    victim_phys;
        logic [PID_W-1:0]   victim_proc;
        logic [COUNT_W-1:0] count;
    } page_res_t;

    typedef struct {
        page_req_t          req;
        bit                 fixed;
        status_t            want_status;
        logic [COUNT_W-1:0] want_count;
    } probe_row_t;

    typedef enum int { MIX_FILL, MIX_CHURN, MIX_TOUCH } mix_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_TRAMPOLINE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    clock_page_replacement_table #(.ENTRIES(ENTRIES)) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // model of the page table
    bit               tab_valid [ENTRIES];
    bit               tab_used  [ENTRIES];
    logic [VA_W-1:0]  tab_virt  [ENTRIES];
    logic [PA_W-1:0]  tab_phys  [ENTRIES];
    logic [PID_W-1:0] tab_proc  [ENTRIES];
    int               sweep_hand = 0;
    int               resident_pages = 0;
    logic [VA_W-1:0]  excl_tramp = TRAMPOLINE_RESET;
    logic [VA_W-1:0]  excl_trap  = TRAPFRAME_RESET;

    page_res_t page_replies_due [$];

    int mismatches = 0;
    int replies_checked = 0;
    int evictions = 0;
    int ignored_reqs = 0;
    int missed_reqs = 0;
    int exclusion_settings = 1;
    int op_tally [4] = '{0, 0, 0, 0};

    // random stimulus knobs
    bit               quiet = 1'b0;
    bit               hold_req = 1'b0;
    int               hold_left = 0;
    mix_t             mix = MIX_FILL;
    logic [VA_W-1:0]  va_base = '0;
    logic [PID_W-1:0] pid_pool [3];
    int               pid_kinds = 1;
    int               idle_cycles = 0;

    probe_row_t probe_rows [21] = '{
        '{'{OP_COUNT,  38'd0, 56'd0, 31'd5}, 1'b1, ST_DONE, 7'd0},
        '{'{OP_REMOVE, 38'd123, 56'd0, 31'd7}, 1'b1, ST_NO_MATCH, 7'd0},
        '{'{OP_TOUCH,  38'd0, 56'd0, 31'd0}, 1'b1, ST_IGNORED, 7'd0},
        '{'{OP_ADD,    38'd1, 56'd1, 31'd0}, 1'b1, ST_IGNORED, 7'd0},
        '{'{OP_ADD,    TRAMPOLINE_RESET, 56'd9, 31'd3}, 1'b1, ST_IGNORED, 7'd0},
        '{'{OP_REMOVE, TRAPFRAME_RESET, 56'd0, 31'd3}, 1'b1, ST_IGNORED, 7'd0},
        '{'{OP_TOUCH,  TRAMPOLINE_RESET, 56'd0, 31'd3}, 1'b1, ST_NO_MATCH, 7'd0},
        '{'{OP_ADD,    VA_ONES, PA_ONES, PID_ONES}, 1'b1, ST_DONE, 7'd0},
        '{'{OP_ADD,    38'd0, 56'd0, 31'd1}, 1'b1, ST_DONE, 7'd0},
        '{'{OP_ADD,    38'h2A_AAAA_AAAA, 56'h55_5555_5555_5555, 31'h2AAA_AAAA},
          1'b0, ST_DONE, 7'd0},
        '{'{OP_ADD,    38'd0, 56'd5, 31'd1}, 1'b0, ST_DONE, 7'd0},
        '{'{OP_TOUCH,  38'd0, 56'd0, 31'd1}, 1'b1, ST_DONE, 7'd0},
        '{'{OP_TOUCH,  38'd0, 56'd0, 31'd2}, 1'b1, ST_NO_MATCH, 7'd0},
        '{'{OP_COUNT,  38'd0, 56'd0, PID_ONES}, 1'b1, ST_DONE, 7'd1},
        '{'{OP_COUNT,  38'd0, 56'd0, 31'd1}, 1'b0, ST_DONE, 7'd0},
        '{'{OP_REMOVE, VA_ONES, 56'd0, PID_ONES}, 1'b1, ST_DONE, 7'd0},
        '{'{OP_REMOVE, VA_ONES, 56'd0, PID_ONES}, 1'b1, ST_NO_MATCH, 7'd0},
        '{'{OP_COUNT,  38'd0, 56'd0, 31'd0}, 1'b1, ST_DONE, 7'd0},
        '{'{OP_REMOVE, 38'd0, 56'd0, 31'd0}, 1'b1, ST_NO_MATCH, 7'd0},
        '{'{OP_COUNT,  38'd0, 56'd0, 31'h2AAA_AAAA}, 1'b0, ST_DONE, 7'd0},
        '{'{OP_TOUCH,  38'h2A_AAAA_AAAA, 56'd0, 31'h2AAA_AAAA}, 1'b0, ST_DONE, 7'd0}
    };

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int find_slot(logic [VA_W-1:0] va, logic [PID_W-1:0] pid);
        for (int i = 0; i < ENTRIES; i++)
            if (tab_valid[i] && tab_virt[i] == va && tab_proc[i] == pid)
                return i;
        return -1;
    endfunction

    function automatic int pick_resident();
        int s;
        do
            s = $urandom_range(ENTRIES - 1);
        while (!tab_valid[s]);
        return s;
    endfunction

    function automatic page_res_t apply_page_op(page_req_t r);
        page_res_t   res;
        bit          excluded;
        int          slot;
        int unsigned tally;
        res = '0;
        res.status = ST_DONE;
        excluded = (r.va == excl_tramp) || (r.va == excl_trap);
        case (r.op)
            OP_ADD:
            begin
                if (r.pid == '0 || excluded)
                    res.status = ST_IGNORED;
                else
                begin
                    if (resident_pages >= ENTRIES)
                    begin
                        for (int n = 0; n < ENTRIES; n++)
                        begin
                            if (tab_valid[sweep_hand] && !tab_used[sweep_hand])
                                break;
                            if (tab_valid[sweep_hand])
                                tab_used[sweep_hand] = 1'b0;
                            sweep_hand = (sweep_hand + 1) % ENTRIES;
                        end
                        tab_valid[sweep_hand] = 1'b0;
                        tab_used[sweep_hand] = 1'b0;
                        resident_pages--;
                        res.evicted = 1'b1;
                        res.victim_virt = tab_virt[sweep_hand];
                        res.victim_phys = tab_phys[sweep_hand];
                        res.victim_proc = tab_proc[sweep_hand];
                        evictions++;
                    end
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (!tab_valid[i])
                        begin
                            tab_virt[i] = r.va;
                            tab_phys[i] = r.pa;
                            tab_proc[i] = r.pid;
                            tab_used[i] = 1'b1;
                            tab_valid[i] = 1'b1;
                            resident_pages++;
                            break;
                        end
                    end
                end
            end
            OP_REMOVE:
            begin
                if (excluded)
                    res.status = ST_IGNORED;
                else
                begin
                    slot = find_slot(r.va, r.pid);
                    if (slot < 0)
                        res.status = ST_NO_MATCH;
                    else
                    begin
                        tab_valid[slot] = 1'b0;
                        tab_used[slot] = 1'b0;
                        if (resident_pages > 0)
                            resident_pages--;
                    end
                end
            end
            OP_TOUCH:
            begin
                if (r.pid == '0)
                    res.status = ST_IGNORED;
                else
                begin
                    slot = find_slot(r.va, r.pid);
                    if (slot < 0)
                        res.status = ST_NO_MATCH;
                    else
                        tab_used[slot] = 1'b1;
                end
            end
            default:
            begin
                tally = 0;
                for (int i = 0; i < ENTRIES; i++)
                    if (tab_valid[i] && tab_proc[i] == r.pid)
                        tally++;
                res.count = (tally > 127) ? 7'd127 : COUNT_W'(tally);
            end
        endcase
        return res;
    endfunction

    function automatic page_req_t next_random_request();
        page_req_t r;
        int        pick;
        int        add_lim;
        int        rem_lim;
        int        tch_lim;
        int        s;
        case (mix)
            MIX_FILL:
            begin
                add_lim = 70; rem_lim = 75; tch_lim = 90;
            end
            MIX_CHURN:
            begin
                add_lim = 30; rem_lim = 65; tch_lim = 85;
            end
            default:
            begin
                add_lim = 20; rem_lim = 30; tch_lim = 85;
            end
        endcase
        pick = $urandom_range(99);
        r.op = (pick < add_lim) ? OP_ADD :
               (pick < rem_lim) ? OP_REMOVE :
               (pick < tch_lim) ? OP_TOUCH : OP_COUNT;
        r.pa = PA_W'(rand64());
        if ((r.op == OP_REMOVE || r.op == OP_TOUCH) && resident_pages > 0
            && $urandom_range(3) != 0)
        begin
            s = pick_resident();
            r.va = tab_virt[s];
            r.pid = tab_proc[s];
        end
        else
        begin
            pick = $urandom_range(99);
            r.va = (pick < 3)  ? excl_tramp :
                   (pick < 6)  ? excl_trap :
                   (pick < 12) ? VA_W'(rand64()) :
                   va_base + VA_W'($urandom_range(11));
            pick = $urandom_range(99);
            r.pid = (pick < 4) ? '0 :
                    (pick < 8) ? PID_W'($urandom) :
                    pid_pool[$urandom_range(pid_kinds - 1)];
        end
        return r;
    endfunction

    task automatic issue_request(input page_req_t r, input bit use_fixed,
                                 input page_res_t fixed_reply, output status_t st);
        page_res_t res;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, r.pid, r.pa, r.va, r.op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        res = apply_page_op(r);
        page_replies_due.push_back(use_fixed ? fixed_reply : res);
        op_tally[r.op]++;
        if (res.status == ST_IGNORED)
            ignored_reqs++;
        if (res.status == ST_NO_MATCH)
            missed_reqs++;
        st = res.status;
    endtask

    task automatic maybe_pause();
        int gap;
        if (!quiet && $urandom_range(99) < 33)
        begin
            gap = ($urandom_range(7) == 0) ? $urandom_range(8, 80) : $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        while (page_replies_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("%0t ERROR %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // reply side: check, then choose next ready
    always @(posedge clk)
    begin : reply_side
        page_res_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            replies_checked++;
            if (page_replies_due.size() == 0)
                flag_mismatch("reply with no request outstanding",
                              64'(m_axis_tdata[1:0]), 64'd0);
            else
            begin
                want = page_replies_due.pop_front();
                if (m_axis_tdata[1:0] !== want.status)
                    flag_mismatch("status", 64'(m_axis_tdata[1:0]), 64'(want.status));
                if (m_axis_tdata[2] !== want.evicted)
                    flag_mismatch("evicted", 64'(m_axis_tdata[2]), 64'(want.evicted));
                if (m_axis_tdata[40:3] !== want.victim_virt)
                    flag_mismatch("victim_virt", 64'(m_axis_tdata[40:3]),
                                  64'(want.victim_virt));
                if (m_axis_tdata[96:41] !== want.victim_phys)
                    flag_mismatch("victim_phys", 64'(m_axis_tdata[96:41]),
                                  64'(want.victim_phys));
                if (m_axis_tdata[127:97] !== want.victim_proc)
                    flag_mismatch("victim_proc", 64'(m_axis_tdata[127:97]),
                                  64'(want.victim_proc));
                if (m_axis_tdata[134:128] !== want.count)
                    flag_mismatch("page_count", 64'(m_axis_tdata[134:128]),
                                  64'(want.count));
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_LEN;
            m_axis_tready <= 1'b0;
        end
        else if (quiet)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= 33);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_CAP)
        begin
            $display("no progress for %0d cycles", STALL_CAP);
            $display("clock_page_replacement_table_tb: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        page_req_t        req;
        page_res_t        fixed_reply;
        status_t          st;
        int               useful;
        int               mark;
        logic [VA_W-1:0]  new_tramp;
        logic [VA_W-1:0]  new_trap;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (probe_rows[k])
        begin
            maybe_pause();
            fixed_reply = '0;
            fixed_reply.status = probe_rows[k].want_status;
            fixed_reply.count = probe_rows[k].want_count;
            issue_request(probe_rows[k].req, probe_rows[k].fixed, fixed_reply, st);
        end

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg > 0)
            begin
                drain_replies();
                case (seg)
                    1:
                    begin
                        new_tramp = '0;
                        new_trap = VA_ONES;
                    end
                    2:
                    begin
                        new_tramp = (resident_pages > 0) ? tab_virt[pick_resident()]
                                                         : VA_W'(rand64());
                        new_trap = VA_W'(rand64());
                    end
                    3:
                    begin
                        new_tramp = VA_W'(rand64());
                        new_trap = VA_W'(rand64());
                    end
                    default:
                    begin
                        new_tramp = VA_ONES;
                        new_trap = '0;
                    end
                endcase
                cfg_wr_en <= 1'b1;
                cfg_index <= REG_TRAMPOLINE;
                cfg_data <= new_tramp;
                @(posedge clk);
                cfg_index <= REG_TRAPFRAME;
                cfg_data <= new_trap;
                @(posedge clk);
                cfg_wr_en <= 1'b0;
                excl_tramp = new_tramp;
                excl_trap = new_trap;
                exclusion_settings++;
            end
            quiet = (seg == 3);
            useful = 0;
            mark = 0;
            while (useful < SEG_ITEMS)
            begin
                if (mark % BLOCK_LEN == 0)
                begin
                    // first block is add-heavy, meant to fill the table, with one pooled owner
                    mix = (seg == 0 && mark == 0) ? MIX_FILL : mix_t'($urandom_range(2));
                    va_base = VA_W'(rand64());
                    pid_pool[0] = PID_W'($urandom_range(1, 3));
                    pid_pool[1] = $urandom_range(1) ? PID_ONES : (PID_W'($urandom) | 31'd1);
                    pid_pool[2] = PID_W'($urandom) | 31'd1;
                    pid_kinds = (seg == 0 && mark == 0) ? 1 : $urandom_range(1, 3);
                end
                if (seg == 1 && mark == 30)
                    hold_req = 1'b1;
                if (seg == 2 && mark == 100)
                    drain_replies();
                if (seg == 3 && mark == 150)
                    quiet = 1'b0;
                maybe_pause();
                req = next_random_request();
                issue_request(req, 1'b0, '0, st);
                if (st != ST_IGNORED)
                    useful++;
                mark++;
            end
        end

        drain_replies();

        $display("requests: %0d add, %0d remove, %0d touch, %0d count; %0d ignored, %0d no match",
                 op_tally[OP_ADD], op_tally[OP_REMOVE], op_tally[OP_TOUCH],
                 op_tally[OP_COUNT], ignored_reqs, missed_reqs);
        $display("%0d replies checked, %0d evictions, %0d excluded-page settings",
                 replies_checked, evictions, exclusion_settings);
        if (mismatches == 0)
            $display("clock_page_replacement_table_tb: done, clean");
        else
            $display("clock_page_replacement_table_tb: done, errors");
        $finish;
    end

endmodule
